// ===== rtl/dtpw_pkg.sv =====
`timescale 1ns / 1ps

package dtpw_pkg;

  localparam int CFG_W   = 9;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 11;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * CFG_W;

  localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

  localparam logic [2:0] REQ_FRAG       = 3'd0;
  localparam logic [2:0] REQ_SET        = 3'd1;
  localparam logic [2:0] REQ_FILL_COLOR = 3'd2;
  localparam logic [2:0] REQ_FILL_DEPTH = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;

  localparam logic [1:0] STAT_WRITTEN = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [1:0] STAT_HIDDEN  = 2'd2;
  localparam logic [1:0] STAT_DONE    = 2'd3;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_CMP,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [PIX_W-1:0] pix;
  } pix_t;

  function automatic pix_t pixel_of(logic [COORD_W-1:0] c, logic trunc_zero);
    pix_t p;
    p.ok  = 1'b0;
    p.pix = '0;
    if (!c[COORD_W-1]) begin
      p.ok  = 1'b1;
      p.pix = c[COORD_W-2:4];
    end else if (trunc_zero && (&c[COORD_W-1:4]) && (c[3:0] != 4'd0)) begin
      p.ok  = 1'b1;
    end
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] r, int unsigned maxv);
    logic [CFG_W-1:0] e;
    if (r == '0) begin
      e = CFG_W'(1);
    end else if (32'(r) > maxv) begin
      e = CFG_W'(maxv);
    end else begin
      e = r;
    end
    return e;
  endfunction

endpackage

// ===== rtl/depth_tested_pixel_writer.sv =====
`timescale 1ns / 1ps

// Depth-tested pixel writer. Colour and depth live in two single-port-write
// memories of MAX_WIDTH * MAX_HEIGHT words each, rows stored bottom-up, and
// their contents are undefined until written, so no clearing pass runs after
// reset. One item is worked on at a time, and its result goes into an output
// register so the next item is taken while the result waits. A depth-tested
// fragment or a read passes through locate, address multiply, memory read,
// compare and write; a clipped set through locate, address multiply and the
// write; an item outside the frame or of unknown kind through locate and
// address multiply only; and a fill writes one entry per cycle over width *
// height entries. The user must write configuration through the APB port only
// while no item is in flight; the block itself does not enforce this.
module depth_tested_pixel_writer import dtpw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                req_type,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic signed [DATA_W-1:0]  depth,
  input  logic [DATA_W-1:0]         color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [DATA_W-1:0]         read_color,
  output logic signed [DATA_W-1:0]  read_depth
);

  localparam int WORDS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(WORDS);

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [CFG_W-1:0]  width_eff;
  logic [CFG_W-1:0]  height_eff;

  state_t            state;
  state_t            state_next;
  logic [2:0]        req;
  logic [DATA_W-1:0] frag_depth;
  logic [DATA_W-1:0] frag_color;
  logic [1:0]        res_status;
  logic [1:0]        res_status_next;
  logic [DATA_W-1:0] res_color;
  logic [DATA_W-1:0] res_color_next;
  logic [DATA_W-1:0] res_depth;
  logic [DATA_W-1:0] res_depth_next;
  logic [ADDR_W-1:0] fill_index;
  logic [ADDR_W-1:0] fill_index_next;

  logic              accept;
  logic              in_frame;
  logic [ADDR_W-1:0] addr;

  logic [DATA_W-1:0] color_mem [WORDS];
  logic [DATA_W-1:0] depth_mem [WORDS];
  logic [DATA_W-1:0] color_rd;
  logic [DATA_W-1:0] depth_rd;
  logic              color_we;
  logic              depth_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] color_wd;
  logic [DATA_W-1:0] depth_wd;
  logic              load_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FRAME_HEIGHT[2]) begin
        frame_height <= pwdata[CFG_W-1:0];
      end else begin
        frame_width <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_HEIGHT[2]) begin
      prdata = 32'(frame_height);
    end else begin
      prdata = 32'(frame_width);
    end
  end

  assign width_eff  = eff_size(frame_width, MAX_WIDTH);
  assign height_eff = eff_size(frame_height, MAX_HEIGHT);

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  dtpw_locate #(
    .ADDR_W(ADDR_W)
  ) u_locate (
    .clk       (clk),
    .capture   (accept),
    .req_type  (req_type),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .in_frame  (in_frame),
    .addr      (addr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      frag_depth <= depth;
      frag_color <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[wr_addr] <= color_wd;
    end
    color_rd <= color_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[wr_addr] <= depth_wd;
    end
    depth_rd <= depth_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      req        <= REQ_FRAG;
      fill_index <= '0;
    end else begin
      state      <= state_next;
      fill_index <= fill_index_next;
      if (accept) begin
        req <= req_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_color  <= res_color_next;
    res_depth  <= res_depth_next;
  end

  always_comb begin
    state_next      = state;
    fill_index_next = fill_index;
    res_status_next = res_status;
    res_color_next  = res_color;
    res_depth_next  = res_depth;
    color_we        = 1'b0;
    depth_we        = 1'b0;
    wr_addr         = addr;
    color_wd        = frag_color;
    depth_wd        = frag_depth;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        res_status_next = STAT_OUTSIDE;
        res_color_next  = '0;
        res_depth_next  = '0;
        if (accept) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (req == REQ_FILL_COLOR || req == REQ_FILL_DEPTH) begin
          fill_index_next = '0;
          state_next      = S_FILL;
        end else if ((req == REQ_FRAG || req == REQ_SET || req == REQ_READ) && in_frame) begin
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        if (req == REQ_SET) begin
          color_we        = 1'b1;
          res_status_next = STAT_WRITTEN;
          state_next      = S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (req == REQ_READ) begin
          res_status_next = STAT_DONE;
          res_color_next  = color_rd;
          res_depth_next  = depth_rd;
        end else if ($signed(frag_depth) > $signed(depth_rd)) begin
          color_we        = 1'b1;
          depth_we        = 1'b1;
          res_status_next = STAT_WRITTEN;
        end else begin
          res_status_next = STAT_HIDDEN;
        end
        state_next = S_DONE;
      end
      S_FILL: begin
        wr_addr  = fill_index;
        color_we = (req == REQ_FILL_COLOR);
        depth_we = (req == REQ_FILL_DEPTH);
        if (fill_index == addr) begin
          fill_index_next = '0;
          res_status_next = STAT_DONE;
          state_next      = S_DONE;
        end else begin
          fill_index_next = fill_index + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= res_status;
      read_color <= res_color;
      read_depth <= res_depth;
    end
  end

endmodule

// ===== rtl/dtpw_locate.sv =====
`timescale 1ns / 1ps

module dtpw_locate import dtpw_pkg::*; #(
  parameter int ADDR_W = 16
) (
  input  logic                      clk,
  input  logic                      capture,
  input  logic [2:0]                req_type,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic [CFG_W-1:0]          width_eff,
  input  logic [CFG_W-1:0]          height_eff,
  output logic                      in_frame,
  output logic [ADDR_W-1:0]         addr
);

  pix_t             px;
  pix_t             py;
  logic             trunc_zero;
  logic [CFG_W-1:0] u;
  logic [CFG_W-1:0] v;
  logic             is_fill;
  logic [CFG_W-1:0] row_op;
  logic [PROD_W-1:0] addend;
  logic [PROD_W-1:0] sum;

  assign trunc_zero = (req_type != REQ_FRAG);
  assign px = pixel_of(x_pos, trunc_zero);
  assign py = pixel_of(y_pos, trunc_zero);

  always_ff @(posedge clk) begin
    if (capture) begin
      in_frame <= px.ok && py.ok && (px.pix < PIX_W'(width_eff))
                  && (py.pix < PIX_W'(height_eff));
      u        <= px.pix[CFG_W-1:0];
      v        <= py.pix[CFG_W-1:0];
      is_fill  <= (req_type == REQ_FILL_COLOR) || (req_type == REQ_FILL_DEPTH);
    end
  end

  // For a fill the same multiplier yields the last entry, width * height - 1.
  always_comb begin
    if (is_fill) begin
      row_op = height_eff;
      addend = '1;
    end else begin
      row_op = height_eff - CFG_W'(1) - v;
      addend = PROD_W'(u);
    end
    sum = PROD_W'(row_op) * PROD_W'(width_eff) + addend;
  end

  always_ff @(posedge clk) begin
    addr <= ADDR_W'(sum);
  end

endmodule

// ===== bench/depth_tested_pixel_writer_tb.sv =====
`timescale 1ns / 1ps

module depth_tested_pixel_writer_tb;
  import dtpw_pkg::*;

  localparam int FRAME_MAX = 256;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 84;
  localparam logic [31:0] BACK_COLOR = 32'hA5A5_5A5A;
  localparam logic [31:0] BACK_DEPTH = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] dep;
    logic [31:0] col;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rcol;
    logic [31:0] rdep;
  } answer_t;

  typedef struct packed {
    request_t rq;
    logic     known;
    answer_t  ans;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                req_type = '0;
  logic signed [COORD_W-1:0] x_pos = '0;
  logic signed [COORD_W-1:0] y_pos = '0;
  logic signed [DATA_W-1:0]  depth = '0;
  logic [DATA_W-1:0]         color = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic [DATA_W-1:0]         read_color;
  logic signed [DATA_W-1:0]  read_depth;

  logic [31:0] color_mem [0:FRAME_MAX*FRAME_MAX-1];
  logic [31:0] depth_mem [0:FRAME_MAX*FRAME_MAX-1];
  logic [8:0]  frame_w_reg = FRAME_RESET;
  logic [8:0]  frame_h_reg = FRAME_RESET;

  answer_t answers_due [$];
  answer_t oldest;
  int      mismatches = 0;
  int      tx_idle_pct = 18;
  int      rx_idle_pct = 52;

  depth_tested_pixel_writer uut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int used_size(logic [8:0] r);
    if (r == 9'd0) return 1;
    if (r > FRAME_MAX) return FRAME_MAX;
    return int'(r);
  endfunction

  function automatic answer_t apply_request(request_t rq);
    answer_t ans;
    int w, h, u, v, a, xs, ys;
    ans = '{STAT_OUTSIDE, 32'h0, 32'h0};
    w = used_size(frame_w_reg);
    h = used_size(frame_h_reg);
    xs = $signed(rq.x);
    ys = $signed(rq.y);
    case (rq.req)
      REQ_FRAG: begin
        if (xs >= 0 && ys >= 0) begin
          u = xs >>> 4;
          v = ys >>> 4;
          if (u < w && v < h) begin
            a = (h - 1 - v) * w + u;
            if ($signed(depth_mem[a]) >= $signed(rq.dep)) begin
              ans.status = STAT_HIDDEN;
            end else begin
              depth_mem[a] = rq.dep;
              color_mem[a] = rq.col;
              ans.status = STAT_WRITTEN;
            end
          end
        end
      end
      REQ_SET, REQ_READ: begin
        if (xs > -16 && ys > -16) begin
          u = (xs < 0) ? 0 : (xs >>> 4);
          v = (ys < 0) ? 0 : (ys >>> 4);
          if (u < w && v < h) begin
            a = (h - 1 - v) * w + u;
            if (rq.req == REQ_SET) begin
              color_mem[a] = rq.col;
              ans.status = STAT_WRITTEN;
            end else begin
              ans = '{STAT_DONE, color_mem[a], depth_mem[a]};
            end
          end
        end
      end
      REQ_FILL_COLOR: begin
        for (int i = 0; i < w * h; i++) color_mem[i] = rq.col;
        ans.status = STAT_DONE;
      end
      REQ_FILL_DEPTH: begin
        for (int i = 0; i < w * h; i++) depth_mem[i] = rq.dep;
        ans.status = STAT_DONE;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic logic [15:0] pick_coord(int size);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 16'($urandom_range(0, size * 16 - 1));
    if (roll < 90) return 16'(size * 16 - 40 + int'($urandom_range(0, 60)));
    if (roll < 95) return 16'(-int'($urandom_range(1, 40)));
    return 16'($urandom);
  endfunction

  task automatic send_request(input request_t rq, input logic known, input answer_t typed);
    answer_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq.req;
    x_pos <= rq.x;
    y_pos <= rq.y;
    depth <= rq.dep;
    color <= rq.col;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(rq);
    answers_due.push_back(known ? typed : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [8:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {23'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected item status %0d color %h depth %h", $time, status,
                 read_color, read_depth);
        mismatches++;
      end else begin
        oldest = answers_due.pop_front();
        if (status !== oldest.status) begin
          $display("%0t: status expected %0d, got %0d", $time, oldest.status, status);
          mismatches++;
        end
        if (read_color !== oldest.rcol) begin
          $display("%0t: read_color expected %h, got %h", $time, oldest.rcol, read_color);
          mismatches++;
        end
        if (read_depth !== oldest.rdep) begin
          $display("%0t: read_depth expected %h, got %h", $time, oldest.rdep, read_depth);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t  directed [$];
    request_t   rq;
    answer_t    none;
    int         w, h, roll;
    logic [8:0] new_w, new_h;
    int         fixed_w [7] = '{1, 256, 1, 0, 300, 1, 16};
    int         fixed_h [7] = '{1, 1, 256, 0, 1, 511, 16};

    none = '0;
    directed.push_back('{'{REQ_FILL_COLOR, 16'h0000, 16'h0000, 32'h0, BACK_COLOR}, 1'b1,
                         '{STAT_DONE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FILL_DEPTH, 16'h0000, 16'h0000, BACK_DEPTH, 32'h0}, 1'b1,
                         '{STAT_DONE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h0000, 16'h0000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_DONE, BACK_COLOR, BACK_DEPTH}});
    directed.push_back('{'{REQ_READ, 16'hFFFF, 16'hFFF1, 32'h0, 32'h0}, 1'b1,
                         '{STAT_DONE, BACK_COLOR, BACK_DEPTH}});
    directed.push_back('{'{REQ_READ, 16'hFFF0, 16'h0000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h0FFF, 16'h0FFF, 32'h0, 32'h0}, 1'b1,
                         '{STAT_DONE, BACK_COLOR, BACK_DEPTH}});
    directed.push_back('{'{REQ_READ, 16'h1000, 16'h0000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h0000, 16'h7FFF, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h8000, 16'h8000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h0000, 16'h0000, BACK_DEPTH, 32'h1111_2222}, 1'b1,
                         '{STAT_HIDDEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h0035, 16'h0058, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                         '{STAT_WRITTEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h0035, 16'h0058, 32'h7FFF_FFFF, 32'h0}, 1'b1,
                         '{STAT_HIDDEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h0030, 16'h0050, 32'h0001_0000, 32'h0}, 1'b1,
                         '{STAT_HIDDEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h003F, 16'h005F, 32'h0, 32'h0}, 1'b1,
                         '{STAT_DONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF}});
    directed.push_back('{'{REQ_SET, 16'h0035, 16'h0058, 32'h0, 32'h0}, 1'b1,
                         '{STAT_WRITTEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_READ, 16'h0035, 16'h0058, 32'h0, 32'h0}, 1'b1,
                         '{STAT_DONE, 32'h0, 32'h7FFF_FFFF}});
    directed.push_back('{'{REQ_SET, 16'hFFF8, 16'hFFFF, 32'h0, 32'h1234_5678}, 1'b1,
                         '{STAT_WRITTEN, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_SET, 16'h0000, 16'h1000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h0FF0, 16'h0FF0, 32'hFFFF_FFFF, 32'h5555_AAAA}, 1'b0,
                         none});
    directed.push_back('{'{REQ_READ, 16'h0000, 16'h0000, 32'h0, 32'h0}, 1'b0, none});
    directed.push_back('{'{3'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{3'd6, 16'h0000, 16'h0000, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{3'd7, 16'h0010, 16'h0010, 32'h0, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});
    directed.push_back('{'{REQ_FRAG, 16'h7FFF, 16'h0000, 32'h7FFF_FFFF, 32'h0}, 1'b1,
                         '{STAT_OUTSIDE, 32'h0, 32'h0}});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_request(directed[i].rq, directed[i].known, directed[i].ans);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph < 7) begin
        new_w = 9'(fixed_w[ph]);
        new_h = 9'(fixed_h[ph]);
      end else begin
        new_w = 9'($urandom_range(1, 20));
        new_h = 9'($urandom_range(1, 20));
      end
      write_reg(REG_FRAME_WIDTH, new_w);
      frame_w_reg = new_w;
      write_reg(REG_FRAME_HEIGHT, new_h);
      frame_h_reg = new_h;
      w = used_size(new_w);
      h = used_size(new_h);
      if (ph < PHASES / 3) begin
        tx_idle_pct = 18;
        rx_idle_pct = 52;
      end else if (ph < 2 * PHASES / 3) begin
        tx_idle_pct = 52;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // Every entry inside the new frame is written before anything reads it.
      rq = '{REQ_FILL_COLOR, 16'($urandom), 16'($urandom), $urandom, $urandom};
      send_request(rq, 1'b0, none);
      rq = '{REQ_FILL_DEPTH, 16'($urandom), 16'($urandom), $urandom, $urandom};
      send_request(rq, 1'b0, none);

      repeat (ITEMS_PER_PHASE) begin
        rq.x = pick_coord(w);
        rq.y = pick_coord(h);
        rq.col = $urandom;
        case ($urandom_range(0, 9))
          0: rq.dep = 32'h8000_0000;
          1: rq.dep = 32'h7FFF_FFFF;
          default: rq.dep = $urandom;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          rq.req = REQ_FRAG;
        end else if (roll < 60) begin
          rq.req = REQ_SET;
        end else if (roll < 84) begin
          rq.req = REQ_READ;
        end else if (roll < 87) begin
          rq.req = REQ_FILL_COLOR;
        end else if (roll < 90) begin
          rq.req = REQ_FILL_DEPTH;
        end else if (roll < 95) begin
          rq.req = 3'($urandom_range(5, 7));
        end else begin
          rq.req = 3'($urandom_range(0, 7));
          rq.x = 16'($urandom);
          rq.y = 16'($urandom);
        end
        send_request(rq, 1'b0, none);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtpw_pkg.sv
rtl/dtpw_locate.sv
rtl/depth_tested_pixel_writer.sv
bench/depth_tested_pixel_writer_tb.sv
